FILE: rtl/eet_pkg.sv
`default_nettype none

package eet_pkg;

   // Widest line count that the record path can carry; the code byte is 1 << line.
   localparam int MaxLines = 8;

   localparam int StampWidth = 32;

   localparam logic [7:0] RecLead  = 8'h62;
   localparam logic [7:0] RecZero  = 8'h00;
   localparam logic [7:0] RecLen   = 8'h05;
   localparam logic [7:0] StopCode = 8'hFF;

   localparam logic [1:0] ModeRise = 2'b11;
   localparam logic [1:0] ModeFall = 2'b10;
   localparam logic [1:0] ModeBoth = 2'b01;

   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CsrEnableMask = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrEdgeMode   = 2'd1;

   typedef enum logic [2:0] {
      ACT_TICK          = 3'd0,
      ACT_START_CAPTURE = 3'd1,
      ACT_START_COUNTER = 3'd2,
      ACT_STOP          = 3'd3,
      ACT_READ_TIME     = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      JOB_RECORDS = 2'd0,
      JOB_STOP    = 2'd1,
      JOB_TIME    = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type                kind;
      logic [MaxLines-1:0]         fire_mask;
      logic [StampWidth-1:0]       stamp;
   } job_type;

endpackage

`default_nettype wire

FILE: rtl/eet_job_fifo.sv
`default_nettype none

module eet_job_fifo #(
   parameter int Depth = 4
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  wire eet_pkg::job_type push_job,
   output logic                  full,
   input  wire                   pop,
   output eet_pkg::job_type      head_job,
   output logic                  empty
);

   localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;

   eet_pkg::job_type entry_ff [Depth];
   logic [AddrWidth:0] wr_ptr_ff, wr_ptr_in;
   logic [AddrWidth:0] rd_ptr_ff, rd_ptr_in;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[AddrWidth] != rd_ptr_ff[AddrWidth]) &&
                  (wr_ptr_ff[AddrWidth-1:0] == rd_ptr_ff[AddrWidth-1:0]);
   assign head_job = entry_ff[rd_ptr_ff[AddrWidth-1:0]];

   assign wr_ptr_in = wr_ptr_ff + {{AddrWidth{1'b0}}, push};
   assign rd_ptr_in = rd_ptr_ff + {{AddrWidth{1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff[AddrWidth-1:0]] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("job queue written while full");

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("job queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/eet_front.sv
`default_nettype none

module eet_front #(
   parameter int LineCount = 6
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write_enable,
   input  wire  [eet_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire  [2*LineCount-1:0]              csr_write_data,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [2:0]                          req_action,
   input  wire  [LineCount-1:0]                req_line_levels,
   output logic                                job_push,
   output eet_pkg::job_type                    job_out,
   input  wire                                 queue_full
);

   logic [LineCount-1:0]           enable_mask_ff;
   logic [2*LineCount-1:0]         edge_mode_ff;
   logic [eet_pkg::StampWidth-1:0] tick_count_ff, tick_count_in;
   logic                           running_ff, running_in;
   logic                           capture_ff, capture_in;
   logic [LineCount-1:0]           prior_levels_ff, prior_levels_in;

   logic                           accept;
   logic [LineCount-1:0]           fire;
   eet_pkg::action_type            action;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign action    = eet_pkg::action_type'(req_action);

   // An enabled line fires when its level moved in the direction its mode selects.
   always_comb begin
      for (int i = 0; i < LineCount; i++) begin
         logic [1:0] mode;
         logic       now;
         mode = edge_mode_ff[2*i +: 2];
         now  = req_line_levels[i];
         fire[i] = enable_mask_ff[i] && (prior_levels_ff[i] != now) &&
                   ((mode == eet_pkg::ModeBoth) ||
                    ((mode == eet_pkg::ModeRise) && now) ||
                    ((mode == eet_pkg::ModeFall) && !now));
      end
   end

   always_comb begin
      tick_count_in   = tick_count_ff;
      running_in      = running_ff;
      capture_in      = capture_ff;
      prior_levels_in = prior_levels_ff;
      job_push        = 1'b0;
      job_out.kind      = eet_pkg::JOB_RECORDS;
      job_out.fire_mask = '0;
      job_out.fire_mask[LineCount-1:0] = fire;
      job_out.stamp     = tick_count_ff;
      if (accept) begin
         unique case (action)
            eet_pkg::ACT_TICK: begin
               job_push        = capture_ff && (fire != '0);
               tick_count_in   = running_ff ?
                                 tick_count_ff + eet_pkg::StampWidth'(1) : tick_count_ff;
               prior_levels_in = req_line_levels;
            end
            eet_pkg::ACT_START_CAPTURE: begin
               tick_count_in = '0;
               running_in    = 1'b1;
               capture_in    = 1'b1;
            end
            eet_pkg::ACT_START_COUNTER: begin
               tick_count_in = '0;
               running_in    = 1'b1;
               capture_in    = 1'b0;
            end
            eet_pkg::ACT_STOP: begin
               job_push     = 1'b1;
               job_out.kind = eet_pkg::JOB_STOP;
               running_in   = 1'b0;
               capture_in   = 1'b0;
            end
            eet_pkg::ACT_READ_TIME: begin
               job_push     = 1'b1;
               job_out.kind = eet_pkg::JOB_TIME;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff  <= '0;
         edge_mode_ff    <= '0;
         tick_count_ff   <= '0;
         running_ff      <= 1'b0;
         capture_ff      <= 1'b0;
         prior_levels_ff <= '0;
      end else begin
         tick_count_ff   <= tick_count_in;
         running_ff      <= running_in;
         capture_ff      <= capture_in;
         prior_levels_ff <= prior_levels_in;
         if (csr_write_enable && (csr_index == eet_pkg::CsrEnableMask)) begin
            enable_mask_ff <= csr_write_data[LineCount-1:0];
         end
         if (csr_write_enable && (csr_index == eet_pkg::CsrEdgeMode)) begin
            edge_mode_ff <= csr_write_data;
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/eet_back.sv
`default_nettype none

module eet_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire eet_pkg::job_type head_job,
   input  wire                   queue_empty,
   output logic                  job_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_byte
);

   logic                          rsp_valid_ff;
   logic [7:0]                    rsp_out_byte_ff, rsp_out_byte_in;
   logic                          rsp_last_byte_ff, rsp_last_byte_in;
   logic [2:0]                    byte_idx_ff, byte_idx_in;
   logic [eet_pkg::MaxLines-1:0]  done_mask_ff, done_mask_in;

   logic                          load;
   logic                          step;
   logic [eet_pkg::MaxLines-1:0]  remaining;
   logic [eet_pkg::MaxLines-1:0]  lowest;
   logic [7:0]                    stamp_byte;
   logic [7:0]                    record_byte;

   assign load      = !rsp_valid_ff || !rsp_stall;
   assign step      = load && !queue_empty;
   assign remaining = head_job.fire_mask & ~done_mask_ff;
   // Isolating the lowest set bit gives ascending line order and the code byte at once.
   assign lowest    = remaining & (~remaining + eet_pkg::MaxLines'(1));

   always_comb begin
      unique case (byte_idx_ff)
         3'd3:    stamp_byte = head_job.stamp[7:0];
         3'd4:    stamp_byte = head_job.stamp[15:8];
         3'd5:    stamp_byte = head_job.stamp[23:16];
         default: stamp_byte = head_job.stamp[31:24];
      endcase
   end

   always_comb begin
      unique case (byte_idx_ff)
         3'd0:    record_byte = eet_pkg::RecLead;
         3'd1:    record_byte = eet_pkg::RecZero;
         3'd2:    record_byte = eet_pkg::RecLen;
         3'd7:    record_byte = (head_job.kind == eet_pkg::JOB_STOP) ?
                                eet_pkg::StopCode : lowest;
         default: record_byte = stamp_byte;
      endcase
   end

   always_comb begin
      rsp_out_byte_in  = record_byte;
      rsp_last_byte_in = 1'b0;
      byte_idx_in      = byte_idx_ff + 3'd1;
      done_mask_in     = done_mask_ff;
      unique case (head_job.kind)
         eet_pkg::JOB_TIME: begin
            // A time reply is only the four timestamp bytes.
            rsp_out_byte_in = head_job.stamp[8*byte_idx_ff[1:0] +: 8];
            rsp_last_byte_in = (byte_idx_ff == 3'd3);
         end
         eet_pkg::JOB_STOP: begin
            rsp_last_byte_in = (byte_idx_ff == 3'd7);
         end
         default: begin
            if (byte_idx_ff == 3'd7) begin
               rsp_last_byte_in = (lowest == remaining);
               done_mask_in     = done_mask_ff | lowest;
            end
         end
      endcase
      if (rsp_last_byte_in) begin
         byte_idx_in  = '0;
         done_mask_in = '0;
      end
   end

   assign job_pop = step && rsp_last_byte_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         byte_idx_ff  <= '0;
         done_mask_ff <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= !queue_empty;
         end
         if (step) begin
            byte_idx_ff  <= byte_idx_in;
            done_mask_ff <= done_mask_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_out_byte_ff  <= rsp_out_byte_in;
         rsp_last_byte_ff <= rsp_last_byte_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_last_byte = rsp_last_byte_ff;

   assert property (@(posedge clock) disable iff (reset)
      (step && (head_job.kind == eet_pkg::JOB_RECORDS)) |-> (remaining != '0))
      else $error("record job served with no line left to report");

endmodule

`default_nettype wire

FILE: rtl/edge_event_timestamper.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_stall    req_action, req_line_levels
// rsp       out        rsp_valid/rsp_stall    rsp_out_byte, rsp_last_byte
// csr       in         csr_write_enable       csr_index, csr_write_data
//
// A request is taken every cycle while the job queue has room; ticks that fire no
// record leave the queue untouched. While rsp_stall is low the serialiser sends one
// byte per cycle: eight per record, four per time reply, so eight per firing line of a tick.
// Synchronous reset clears the counter, flags, line history, registers and queue.
// req_stall rises only when the job queue is full; rsp_stall holds the output register.

module edge_event_timestamper #(
   parameter int LINE_COUNT  = 6,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_write_enable,
   input  wire  [eet_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire  [2*LINE_COUNT-1:0]            csr_write_data,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [2:0]                         req_action,
   input  wire  [LINE_COUNT-1:0]              req_line_levels,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_last_byte
);

   eet_pkg::job_type push_job;
   eet_pkg::job_type head_job;
   logic             job_push;
   logic             job_pop;
   logic             queue_full;
   logic             queue_empty;

   eet_front #(
      .LineCount (LINE_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_line_levels  (req_line_levels),
      .job_push         (job_push),
      .job_out          (push_job),
      .queue_full       (queue_full)
   );

   eet_job_fifo #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (job_pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   eet_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .queue_empty   (queue_empty),
      .job_pop       (job_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

`default_nettype wire

FILE: bench/edge_event_timestamper_tb.sv
`timescale 1ns / 100ps

module edge_event_timestamper_tb;

   localparam int LineCount = 6;
   localparam int QuietCycles = 40;
   localparam int LongHold = 400;
   localparam int EndLimit = 20000;

   // Action codes that the block must ignore.
   localparam logic [2:0] ActSpare0 = 3'd5;
   localparam logic [2:0] ActSpare1 = 3'd6;
   localparam logic [2:0] ActSpare2 = 3'd7;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } rsp_beat_type;

   typedef struct packed {
      logic [2:0]  act;
      logic [5:0]  lv;
      logic        typed;
      logic [3:0]  count;
      logic [63:0] bytes;   // first byte of the reply sits in the top octet
   } drill_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [eet_pkg::CsrIndexWidth-1:0] csr_index = eet_pkg::CsrEnableMask;
   logic [2*LineCount-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_action = eet_pkg::ACT_TICK;
   logic [LineCount-1:0] req_line_levels = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_last_byte;

   // Typed-in expectation travelling alongside the request payload.
   logic row_typed = 1'b0;
   logic [3:0] row_count = '0;
   logic [63:0] row_bytes = '0;

   // Predictor state and its copy of the registers.
   logic [31:0] stamp_count = '0;
   logic count_running = 1'b0;
   logic capture_armed = 1'b0;
   logic [LineCount-1:0] seen_levels = '0;
   logic [LineCount-1:0] mask_shadow = '0;
   logic [2*LineCount-1:0] mode_shadow = '0;

   rsp_beat_type owed_bytes[$];
   int mismatches = 0;
   bit idle_on = 1'b1;
   bit long_hold_due = 1'b0;
   logic [LineCount-1:0] sent_levels = '0;

   drill_row_type drill_rows [0:26] = '{
      '{eet_pkg::ACT_READ_TIME,     6'h00, 1'b1, 4'd4, 64'h00_00_00_00_00_00_00_00},
      '{eet_pkg::ACT_STOP,          6'h3F, 1'b1, 4'd8, 64'h62_00_05_00_00_00_00_FF},
      '{eet_pkg::ACT_TICK,          6'h3F, 1'b1, 4'd0, 64'h0},
      '{ActSpare0,                  6'h2A, 1'b1, 4'd0, 64'h0},
      '{ActSpare1,                  6'h15, 1'b1, 4'd0, 64'h0},
      '{ActSpare2,                  6'h3F, 1'b1, 4'd0, 64'h0},
      '{eet_pkg::ACT_START_CAPTURE, 6'h00, 1'b1, 4'd0, 64'h0},
      '{eet_pkg::ACT_TICK,          6'h00, 1'b1, 4'd0, 64'h0},
      '{eet_pkg::ACT_TICK,          6'h3F, 1'b1, 4'd0, 64'h0},
      '{eet_pkg::ACT_READ_TIME,     6'h00, 1'b1, 4'd4, 64'h02_00_00_00_00_00_00_00},
      '{eet_pkg::ACT_START_CAPTURE, 6'h3F, 1'b1, 4'd0, 64'h0},
      '{eet_pkg::ACT_TICK,          6'h3F, 1'b1, 4'd0, 64'h0},
      '{eet_pkg::ACT_TICK,          6'h00, 1'b0, 4'd0, 64'h0},
      '{eet_pkg::ACT_TICK,          6'h3F, 1'b0, 4'd0, 64'h0},
      '{eet_pkg::ACT_TICK,          6'h20, 1'b0, 4'd0, 64'h0},
      '{eet_pkg::ACT_TICK,          6'h01, 1'b0, 4'd0, 64'h0},
      '{eet_pkg::ACT_START_COUNTER, 6'h00, 1'b1, 4'd0, 64'h0},
      '{eet_pkg::ACT_TICK,          6'h3E, 1'b1, 4'd0, 64'h0},
      '{eet_pkg::ACT_READ_TIME,     6'h00, 1'b1, 4'd4, 64'h01_00_00_00_00_00_00_00},
      '{eet_pkg::ACT_STOP,          6'h00, 1'b1, 4'd8, 64'h62_00_05_01_00_00_00_FF},
      '{eet_pkg::ACT_STOP,          6'h3F, 1'b1, 4'd8, 64'h62_00_05_01_00_00_00_FF},
      '{eet_pkg::ACT_TICK,          6'h01, 1'b1, 4'd0, 64'h0},
      '{eet_pkg::ACT_READ_TIME,     6'h00, 1'b1, 4'd4, 64'h01_00_00_00_00_00_00_00},
      '{eet_pkg::ACT_START_CAPTURE, 6'h00, 1'b1, 4'd0, 64'h0},
      '{eet_pkg::ACT_TICK,          6'h3F, 1'b0, 4'd0, 64'h0},
      '{eet_pkg::ACT_TICK,          6'h00, 1'b0, 4'd0, 64'h0},
      '{eet_pkg::ACT_READ_TIME,     6'h00, 1'b1, 4'd4, 64'h02_00_00_00_00_00_00_00}
   };

   edge_event_timestamper dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_line_levels  (req_line_levels),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_byte    (rsp_last_byte)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task automatic put_stamp(ref logic [7:0] made[$], input logic [31:0] stamp);
      for (int k = 0; k < 4; k++)
         made.push_back(stamp[8*k +: 8]);
   endtask

   task automatic put_record(ref logic [7:0] made[$], input logic [31:0] stamp,
                             input logic [7:0] code);
      made.push_back(eet_pkg::RecLead);
      made.push_back(eet_pkg::RecZero);
      made.push_back(eet_pkg::RecLen);
      put_stamp(made, stamp);
      made.push_back(code);
   endtask

   // Advances the predicted state by one accepted request and collects its reply bytes.
   task automatic timestamp_step(input logic [2:0] act, input logic [LineCount-1:0] lv,
                                 ref logic [7:0] made[$]);
      logic [1:0] line_mode;
      case (act)
         eet_pkg::ACT_TICK: begin
            if (capture_armed) begin
               for (int i = 0; i < LineCount; i++) begin
                  line_mode = mode_shadow[2*i +: 2];
                  if (mask_shadow[i] && seen_levels[i] != lv[i] &&
                      (line_mode == eet_pkg::ModeBoth ||
                       (line_mode == eet_pkg::ModeRise && lv[i]) ||
                       (line_mode == eet_pkg::ModeFall && !lv[i])))
                     put_record(made, stamp_count, 8'(1 << i));
               end
            end
            if (count_running)
               stamp_count = stamp_count + 32'd1;
            seen_levels = lv;
         end
         eet_pkg::ACT_START_CAPTURE: begin
            stamp_count = '0;
            count_running = 1'b1;
            capture_armed = 1'b1;
         end
         eet_pkg::ACT_START_COUNTER: begin
            stamp_count = '0;
            count_running = 1'b1;
            capture_armed = 1'b0;
         end
         eet_pkg::ACT_STOP: begin
            put_record(made, stamp_count, eet_pkg::StopCode);
            count_running = 1'b0;
            capture_armed = 1'b0;
         end
         eet_pkg::ACT_READ_TIME: begin
            put_stamp(made, stamp_count);
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin : scoreboard
      logic [7:0] made[$];
      rsp_beat_type want;
      if (!reset) begin
         // Check the outgoing byte before queueing this edge's request, so that a
         // spurious byte can never be matched against its own request.
         if (rsp_valid && !rsp_stall) begin
            if (owed_bytes.size() == 0) begin
               report_mismatch($sformatf("byte %02h with nothing outstanding", rsp_out_byte));
            end else begin
               want = owed_bytes.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                            rsp_out_byte, want.data));
               if (rsp_last_byte !== want.last)
                  report_mismatch($sformatf("last_byte %b, wanted %b",
                                            rsp_last_byte, want.last));
            end
         end
         if (req_valid && !req_stall) begin
            made.delete();
            timestamp_step(req_action, req_line_levels, made);
            if (row_typed) begin
               if (made.size() != row_count) begin
                  report_mismatch($sformatf("table row action %0d: %0d bytes predicted, %0d listed",
                                            req_action, made.size(), row_count));
               end else begin
                  foreach (made[k])
                     if (made[k] != row_bytes[63-8*k -: 8])
                        report_mismatch($sformatf("table row action %0d: byte %0d differs",
                                                  req_action, k));
               end
            end
            foreach (made[k])
               owed_bytes.push_back('{data: made[k], last: (k == made.size() - 1)});
         end
      end
   end

   // Receiver: short random stalls, and one long hold-off on request.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LongHold) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 15) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send(input logic [2:0] act, input logic [LineCount-1:0] lv,
                       input logic typed, input logic [3:0] count, input logic [63:0] bytes);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_line_levels <= lv;
      row_typed <= typed;
      row_count <= count;
      row_bytes <= bytes;
      if (act == eet_pkg::ACT_TICK)
         sent_levels = lv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_bytes.size() != 0);
   endtask

   // Registers change only once the block has gone quiet.
   task automatic load_regs(input logic [LineCount-1:0] mask,
                            input logic [2*LineCount-1:0] mode);
      wait_drained();
      repeat (QuietCycles) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= eet_pkg::CsrEnableMask;
      csr_write_data <= {{LineCount{1'b0}}, mask};
      @(posedge clock);
      mask_shadow = mask;
      csr_index <= eet_pkg::CsrEdgeMode;
      csr_write_data <= mode;
      @(posedge clock);
      mode_shadow = mode;
      csr_write_enable <= 1'b0;
   endtask

   task automatic drill(input int first, input int final_row);
      for (int i = first; i <= final_row; i++)
         send(drill_rows[i].act, drill_rows[i].lv, drill_rows[i].typed,
              drill_rows[i].count, drill_rows[i].bytes);
   endtask

   task automatic random_items(input int target);
      int done;
      int pick;
      logic [2:0] act;
      logic [LineCount-1:0] lv;
      done = 0;
      while (done < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            act = eet_pkg::ACT_TICK;
         else if (pick < 78)
            act = eet_pkg::ACT_START_CAPTURE;
         else if (pick < 82)
            act = eet_pkg::ACT_START_COUNTER;
         else if (pick < 88)
            act = eet_pkg::ACT_STOP;
         else if (pick < 94)
            act = eet_pkg::ACT_READ_TIME;
         else
            act = 3'($urandom_range(ActSpare0, ActSpare2));
         // Ticks mostly flip one line, else all lines or random levels, so that edges stay frequent but varied.
         case ($urandom_range(0, 3))
            0: lv = LineCount'($urandom_range(0, 63));
            1, 2: lv = sent_levels ^ LineCount'(1 << $urandom_range(0, LineCount - 1));
            default: lv = ~sent_levels;
         endcase
         send(act, lv, 1'b0, 4'd0, 64'h0);
         if (act <= eet_pkg::ACT_READ_TIME)
            done++;
         if ($urandom_range(0, 99) == 0)
            wait_drained();
      end
   endtask

   initial begin : stimulus
      int spin;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      drill(0, 9);
      load_regs(6'h3F, 12'h1AF);
      drill(10, 22);
      load_regs(6'h3F, 12'h555);
      drill(23, 26);

      load_regs(6'h3F, 12'hFFF);
      random_items(90);
      load_regs(6'h00, 12'h000);
      random_items(40);
      load_regs(LineCount'($urandom_range(0, 63)), 12'($urandom_range(0, 4095)));
      random_items(90);

      // Every line fires on every toggle while the receiver holds off, so the job
      // queue fills and the request side must stall.
      load_regs(6'h3F, 12'h555);
      long_hold_due = 1'b1;
      send(eet_pkg::ACT_START_CAPTURE, 6'h00, 1'b0, 4'd0, 64'h0);
      for (int i = 0; i < 24; i++)
         send(eet_pkg::ACT_TICK, sent_levels ^ 6'h3F, 1'b0, 4'd0, 64'h0);
      wait_drained();
      random_items(80);

      idle_on = 1'b0;
      load_regs(LineCount'($urandom_range(0, 63)), 12'($urandom_range(0, 4095)));
      random_items(80);

      req_valid <= 1'b0;
      spin = 0;
      while (owed_bytes.size() != 0 && spin < EndLimit) begin
         @(posedge clock);
         spin++;
      end
      repeat (QuietCycles) @(posedge clock);
      if (owed_bytes.size() != 0)
         report_mismatch($sformatf("%0d bytes never arrived", owed_bytes.size()));
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: edge_event_timestamper.f
rtl/eet_pkg.sv
rtl/eet_job_fifo.sv
rtl/eet_front.sv
rtl/eet_back.sv
rtl/edge_event_timestamper.sv
bench/edge_event_timestamper_tb.sv
